// ===== src/ulc_pkg.sv =====
`timescale 1ns / 1ps
package ulc_pkg;

	localparam int CpW    = 21;
	localparam int BmpW   = 16;
	localparam int NRules = 42;
	localparam int NPairs = 152;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_OR1
	} op_t;

	typedef struct packed {
		logic [BmpW-1:0] lo;
		logic [BmpW-1:0] hi;
		logic [BmpW-1:0] excl;
		logic [3:0]      mask;
		op_t             op;
		logic [BmpW-1:0] amt;
	} rule_t;

	typedef struct packed {
		logic            rule_hit;
		op_t             op;
		logic [BmpW-1:0] amt;
		logic            pair_hit;
		logic [BmpW-1:0] pair_val;
	} match_t;

	localparam rule_t RULES [NRules] = '{
		'{16'h0041, 16'h005a, 16'h0000, 4'h0, OP_ADD, 16'h0020},
		'{16'h00c0, 16'h00de, 16'h00d7, 4'h0, OP_ADD, 16'h0020},
		'{16'h0100, 16'h012e, 16'h0000, 4'h0, OP_OR1, 16'h0000},
		'{16'h0139, 16'h0147, 16'h0000, 4'h1, OP_ADD, 16'h0001},
		'{16'h014a, 16'h0176, 16'h0000, 4'h0, OP_OR1, 16'h0000},
		'{16'h01cb, 16'h01db, 16'h0000, 4'h1, OP_ADD, 16'h0001},
		'{16'h01de, 16'h01ee, 16'h0000, 4'h0, OP_OR1, 16'h0000},
		'{16'h01f8, 16'h021e, 16'h0000, 4'h0, OP_OR1, 16'h0000},
		'{16'h0222, 16'h0232, 16'h0000, 4'h0, OP_OR1, 16'h0000},
		'{16'h0246, 16'h024e, 16'h0000, 4'h0, OP_OR1, 16'h0000},
		'{16'h0391, 16'h03ab, 16'h03a2, 4'h0, OP_ADD, 16'h0020},
		'{16'h03d8, 16'h03ee, 16'h0000, 4'h0, OP_OR1, 16'h0000},
		'{16'h0400, 16'h040f, 16'h0000, 4'h0, OP_ADD, 16'h0050},
		'{16'h0410, 16'h042f, 16'h0000, 4'h0, OP_ADD, 16'h0020},
		'{16'h0460, 16'h0480, 16'h0000, 4'h0, OP_OR1, 16'h0000},
		'{16'h048a, 16'h04be, 16'h0000, 4'h0, OP_OR1, 16'h0000},
		'{16'h04c1, 16'h04cd, 16'h0000, 4'h1, OP_ADD, 16'h0001},
		'{16'h04d0, 16'h052e, 16'h0000, 4'h0, OP_OR1, 16'h0000},
		'{16'h0531, 16'h0556, 16'h0000, 4'h0, OP_ADD, 16'h0030},
		'{16'h10a0, 16'h10c5, 16'h0000, 4'h0, OP_ADD, 16'h1c60},
		'{16'h13a0, 16'h13ef, 16'h0000, 4'h0, OP_ADD, 16'h97d0},
		'{16'h13f0, 16'h13f5, 16'h0000, 4'h0, OP_ADD, 16'h0008},
		'{16'h1c90, 16'h1cba, 16'h0000, 4'h0, OP_SUB, 16'h0bc0},
		'{16'h1e00, 16'h1e94, 16'h0000, 4'h0, OP_OR1, 16'h0000},
		'{16'h1ea0, 16'h1efe, 16'h0000, 4'h0, OP_OR1, 16'h0000},
		'{16'h1f08, 16'h1f4d, 16'h0000, 4'h8, OP_SUB, 16'h0008},
		'{16'h1f59, 16'h1f5f, 16'h0000, 4'h1, OP_SUB, 16'h0008},
		'{16'h1f68, 16'h1f6f, 16'h0000, 4'h0, OP_SUB, 16'h0008},
		'{16'h1f88, 16'h1faf, 16'h0000, 4'h8, OP_SUB, 16'h0008},
		'{16'h1fc8, 16'h1fcb, 16'h0000, 4'h0, OP_SUB, 16'h0056},
		'{16'h2160, 16'h216f, 16'h0000, 4'h0, OP_ADD, 16'h0010},
		'{16'h24b6, 16'h24cf, 16'h0000, 4'h0, OP_ADD, 16'h001a},
		'{16'h2c00, 16'h2c2e, 16'h0000, 4'h0, OP_ADD, 16'h0030},
		'{16'h2c80, 16'h2ce2, 16'h0000, 4'h0, OP_OR1, 16'h0000},
		'{16'ha640, 16'ha66c, 16'h0000, 4'h0, OP_OR1, 16'h0000},
		'{16'ha680, 16'ha69a, 16'h0000, 4'h0, OP_OR1, 16'h0000},
		'{16'ha722, 16'ha72e, 16'h0000, 4'h0, OP_OR1, 16'h0000},
		'{16'ha732, 16'ha76e, 16'h0000, 4'h0, OP_OR1, 16'h0000},
		'{16'ha77e, 16'ha786, 16'h0000, 4'h0, OP_OR1, 16'h0000},
		'{16'ha796, 16'ha7a8, 16'h0000, 4'h0, OP_OR1, 16'h0000},
		'{16'ha7b4, 16'ha7be, 16'h0000, 4'h0, OP_OR1, 16'h0000},
		'{16'hff21, 16'hff3a, 16'h0000, 4'h0, OP_ADD, 16'h0020}
	};

	localparam logic [31:0] PAIRS [NPairs] = '{
		32'h0130_0069, 32'h0132_0133, 32'h0134_0135, 32'h0136_0137, 32'h0178_00ff,
		32'h0179_017a, 32'h017b_017c, 32'h017d_017e, 32'h0181_0253, 32'h0182_0183,
		32'h0184_0185, 32'h0186_0254, 32'h0187_0188, 32'h0189_0256, 32'h018a_0257,
		32'h018b_018c, 32'h018e_01dd, 32'h018f_0259, 32'h0190_025b, 32'h0191_0192,
		32'h0193_0260, 32'h0194_0263, 32'h0196_0269, 32'h0197_0268, 32'h0198_0199,
		32'h019c_026f, 32'h019d_0272, 32'h019f_0275, 32'h01a0_01a1, 32'h01a2_01a3,
		32'h01a4_01a5, 32'h01a6_0280, 32'h01a7_01a8, 32'h01a9_0283, 32'h01ac_01ad,
		32'h01ae_0288, 32'h01af_01b0, 32'h01b1_028a, 32'h01b2_028b, 32'h01b3_01b4,
		32'h01b5_01b6, 32'h01b7_0292, 32'h01b8_01b9, 32'h01bc_01bd, 32'h01c4_01c6,
		32'h01c5_01c6, 32'h01c7_01c9, 32'h01c8_01c9, 32'h01ca_01cc, 32'h01f1_01f3,
		32'h01f2_01f3, 32'h01f4_01f5, 32'h01f6_0195, 32'h01f7_01bf, 32'h0220_019e,
		32'h023a_2c65, 32'h023b_023c, 32'h023d_019a, 32'h023e_2c66, 32'h0241_0242,
		32'h0243_0180, 32'h0244_0289, 32'h0245_028c, 32'h0370_0371, 32'h0372_0373,
		32'h0376_0377, 32'h037f_03f3, 32'h0386_03ac, 32'h0388_03ad, 32'h0389_03ae,
		32'h038a_03af, 32'h038c_03cc, 32'h038e_03cd, 32'h038f_03ce, 32'h03cf_03d7,
		32'h03f4_03b8, 32'h03f7_03f8, 32'h03f9_03f2, 32'h03fa_03fb, 32'h03fd_037b,
		32'h03fe_037c, 32'h03ff_037d, 32'h04c0_04cf, 32'h10c7_2d27, 32'h10cd_2d2d,
		32'h1cbd_10fd, 32'h1cbe_10fe, 32'h1cbf_10ff, 32'h1e9e_00df, 32'h1fb8_1fb0,
		32'h1fb9_1fb1, 32'h1fba_1f70, 32'h1fbb_1f71, 32'h1fbc_1fb3, 32'h1fcc_1fc3,
		32'h1fd8_1fd0, 32'h1fd9_1fd1, 32'h1fda_1f76, 32'h1fdb_1f77, 32'h1fe8_1fe0,
		32'h1fe9_1fe1, 32'h1fea_1f7a, 32'h1feb_1f7b, 32'h1fec_1fe5, 32'h1ff8_1f78,
		32'h1ff9_1f79, 32'h1ffa_1f7c, 32'h1ffb_1f7d, 32'h1ffc_1ff3, 32'h2126_03c9,
		32'h212a_006b, 32'h212b_00e5, 32'h2132_214e, 32'h2183_2184, 32'h2c60_2c61,
		32'h2c62_026b, 32'h2c63_1d7d, 32'h2c64_027d, 32'h2c67_2c68, 32'h2c69_2c6a,
		32'h2c6b_2c6c, 32'h2c6d_0251, 32'h2c6e_0271, 32'h2c6f_0250, 32'h2c70_0252,
		32'h2c72_2c73, 32'h2c75_2c76, 32'h2c7e_023f, 32'h2c7f_0240, 32'h2ceb_2cec,
		32'h2ced_2cee, 32'h2cf2_2cf3, 32'ha779_a77a, 32'ha77b_a77c, 32'ha77d_1d79,
		32'ha78b_a78c, 32'ha78d_0265, 32'ha790_a791, 32'ha792_a793, 32'ha7aa_0266,
		32'ha7ab_025c, 32'ha7ac_0261, 32'ha7ad_026c, 32'ha7ae_026a, 32'ha7b0_029e,
		32'ha7b1_0287, 32'ha7b2_029d, 32'ha7b3_ab53, 32'ha7c2_a7c3, 32'ha7c4_a794,
		32'ha7c5_0282, 32'ha7c6_1d8e
	};

endpackage

// ===== src/unicode_to_lowercase.sv =====
`timescale 1ns / 1ps
// A request passes the input register, the match register and the output register before its result is valid.
// Throughput: one request per cycle; a stall on the output holds every stage.
// The three stages are input register, rule and pair match, and apply.
// Reset clears the stage valid bits only; payload registers are not reset.
module unicode_to_lowercase
	import ulc_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [CpW-1:0] code_point,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [CpW-1:0] lower_point,
	output logic           changed
);

	logic           en;
	logic           v_s1, v_s2, v_s3;
	logic [CpW-1:0] cp_s1, cp_s2, lo_s3;
	logic           chg_s3;
	match_t         match_s2;
	logic [CpW-1:0] res;

	assign en       = !v_s3 || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cp_s1  <= code_point;
			cp_s2  <= cp_s1;
			lo_s3  <= res;
			chg_s3 <= (res != cp_s2);
		end
	end

	ulc_match u_match (
		.clk      (clk),
		.cp       (cp_s1),
		.en       (en),
		.match_s2 (match_s2)
	);

	always_comb begin
		res = cp_s2;
		if (match_s2.rule_hit) begin
			case (match_s2.op)
				OP_ADD:  res = cp_s2 + {{(CpW-BmpW){1'b0}}, match_s2.amt};
				OP_SUB:  res = cp_s2 - {{(CpW-BmpW){1'b0}}, match_s2.amt};
				OP_OR1:  res = cp_s2 | {{(CpW-1){1'b0}}, 1'b1};
				default: res = cp_s2;
			endcase
		end else if (match_s2.pair_hit) begin
			res = {{(CpW-BmpW){1'b0}}, match_s2.pair_val};
		end
	end

	assign out_valid   = v_s3;
	assign lower_point = lo_s3;
	assign changed     = chg_s3;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !out_ready) |=> (v_s3 && $stable(lo_s3) && $stable(v_s2) && $stable(v_s1)))
		else $error("stalled pipeline moved");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s2) |=> v_s3)
		else $error("request lost between stages");

	a_bmp_only: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && chg_s3) |-> (lo_s3[CpW-1:BmpW] == '0))
		else $error("mapping left the basic plane");

endmodule

// ===== src/ulc_match.sv =====
`timescale 1ns / 1ps
module ulc_match
	import ulc_pkg::*;
(
	input  logic           clk,
	input  logic [CpW-1:0] cp,
	input  logic           en,
	output match_t         match_s2
);

	match_t m;
	logic   bmp;
	logic [BmpW-1:0] c;

	assign bmp = (cp[CpW-1:BmpW] == '0);
	assign c   = cp[BmpW-1:0];

	// scan from the last rule so the earliest match wins
	always_comb begin
		m = '0;
		for (int i = NRules - 1; i >= 0; i--) begin
			if (bmp && c >= RULES[i].lo && c <= RULES[i].hi
				&& !(RULES[i].excl != '0 && c == RULES[i].excl)
				&& !(RULES[i].mask != '0 && (c[3:0] & RULES[i].mask) == '0)) begin
				m.rule_hit = 1'b1;
				m.op       = RULES[i].op;
				m.amt      = RULES[i].amt;
			end
		end
		for (int j = 0; j < NPairs; j++) begin
			if (bmp && c == PAIRS[j][31:16]) begin
				m.pair_hit = 1'b1;
				m.pair_val = PAIRS[j][15:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			match_s2 <= m;
		end
	end

endmodule

// ===== verif/ulc_checker.sv =====
`timescale 1ns / 1ps
module ulc_checker
	import ulc_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_ready,
	input  logic [CpW-1:0] code_point,
	input  logic           out_valid,
	input  logic           out_ready,
	input  logic [CpW-1:0] lower_point,
	input  logic           changed,
	output int             errors,
	output int             pending
);

	typedef struct packed {
		logic [CpW-1:0] point;
		logic           flag;
	} folded_t;

	typedef struct {
		int unsigned lo, hi, excl, mask;
		op_t         op;
		int unsigned amt;
	} span_t;

	span_t       spans [$];
	int unsigned swaps [int unsigned];
	folded_t     folded_q [$];

	function automatic void add_span(int unsigned lo, int unsigned hi, int unsigned excl,
			int unsigned mask, op_t op, int unsigned amt);
		span_t s;
		s.lo = lo; s.hi = hi; s.excl = excl; s.mask = mask; s.op = op; s.amt = amt;
		spans.push_back(s);
	endfunction

	function automatic folded_t fold(logic [CpW-1:0] cp);
		folded_t f;
		int unsigned v;
		int unsigned r;
		bit done;
		v = 32'(cp);
		r = v;
		done = 0;
		foreach (spans[i]) begin
			if (!done && v >= spans[i].lo && v <= spans[i].hi
					&& !(spans[i].excl != 0 && v == spans[i].excl)
					&& !(spans[i].mask != 0 && (v & spans[i].mask) == 0)) begin
				done = 1;
				case (spans[i].op)
					OP_ADD: r = v + spans[i].amt;
					OP_SUB: r = v - spans[i].amt;
					default: r = v | 1;
				endcase
			end
		end
		if (!done && swaps.exists(v))
			r = swaps[v];
		f.point = r[CpW-1:0];
		f.flag = (f.point != cp);
		return f;
	endfunction

	initial begin
		add_span('h41, 'h5a, 0, 0, OP_ADD, 'h20);
		add_span('hc0, 'hde, 'hd7, 0, OP_ADD, 'h20);
		add_span('h100, 'h12e, 0, 0, OP_OR1, 0);
		add_span('h139, 'h147, 0, 1, OP_ADD, 1);
		add_span('h14a, 'h176, 0, 0, OP_OR1, 0);
		add_span('h1cb, 'h1db, 0, 1, OP_ADD, 1);
		add_span('h1de, 'h1ee, 0, 0, OP_OR1, 0);
		add_span('h1f8, 'h21e, 0, 0, OP_OR1, 0);
		add_span('h222, 'h232, 0, 0, OP_OR1, 0);
		add_span('h246, 'h24e, 0, 0, OP_OR1, 0);
		add_span('h391, 'h3ab, 'h3a2, 0, OP_ADD, 'h20);
		add_span('h3d8, 'h3ee, 0, 0, OP_OR1, 0);
		add_span('h400, 'h40f, 0, 0, OP_ADD, 'h50);
		add_span('h410, 'h42f, 0, 0, OP_ADD, 'h20);
		add_span('h460, 'h480, 0, 0, OP_OR1, 0);
		add_span('h48a, 'h4be, 0, 0, OP_OR1, 0);
		add_span('h4c1, 'h4cd, 0, 1, OP_ADD, 1);
		add_span('h4d0, 'h52e, 0, 0, OP_OR1, 0);
		add_span('h531, 'h556, 0, 0, OP_ADD, 'h30);
		add_span('h10a0, 'h10c5, 0, 0, OP_ADD, 'h1c60);
		add_span('h13a0, 'h13ef, 0, 0, OP_ADD, 'h97d0);
		add_span('h13f0, 'h13f5, 0, 0, OP_ADD, 'h8);
		add_span('h1c90, 'h1cba, 0, 0, OP_SUB, 'hbc0);
		add_span('h1e00, 'h1e94, 0, 0, OP_OR1, 0);
		add_span('h1ea0, 'h1efe, 0, 0, OP_OR1, 0);
		add_span('h1f08, 'h1f4d, 0, 8, OP_SUB, 'h8);
		add_span('h1f59, 'h1f5f, 0, 1, OP_SUB, 'h8);
		add_span('h1f68, 'h1f6f, 0, 0, OP_SUB, 'h8);
		add_span('h1f88, 'h1faf, 0, 8, OP_SUB, 'h8);
		add_span('h1fc8, 'h1fcb, 0, 0, OP_SUB, 'h56);
		add_span('h2160, 'h216f, 0, 0, OP_ADD, 'h10);
		add_span('h24b6, 'h24cf, 0, 0, OP_ADD, 'h1a);
		add_span('h2c00, 'h2c2e, 0, 0, OP_ADD, 'h30);
		add_span('h2c80, 'h2ce2, 0, 0, OP_OR1, 0);
		add_span('ha640, 'ha66c, 0, 0, OP_OR1, 0);
		add_span('ha680, 'ha69a, 0, 0, OP_OR1, 0);
		add_span('ha722, 'ha72e, 0, 0, OP_OR1, 0);
		add_span('ha732, 'ha76e, 0, 0, OP_OR1, 0);
		add_span('ha77e, 'ha786, 0, 0, OP_OR1, 0);
		add_span('ha796, 'ha7a8, 0, 0, OP_OR1, 0);
		add_span('ha7b4, 'ha7be, 0, 0, OP_OR1, 0);
		add_span('hff21, 'hff3a, 0, 0, OP_ADD, 'h20);
		swaps = '{
			'h130:'h69, 'h132:'h133, 'h134:'h135, 'h136:'h137, 'h178:'hff, 'h179:'h17a,
			'h17b:'h17c, 'h17d:'h17e, 'h181:'h253, 'h182:'h183, 'h184:'h185, 'h186:'h254,
			'h187:'h188, 'h189:'h256, 'h18a:'h257, 'h18b:'h18c, 'h18e:'h1dd, 'h18f:'h259,
			'h190:'h25b, 'h191:'h192, 'h193:'h260, 'h194:'h263, 'h196:'h269, 'h197:'h268,
			'h198:'h199, 'h19c:'h26f, 'h19d:'h272, 'h19f:'h275, 'h1a0:'h1a1, 'h1a2:'h1a3,
			'h1a4:'h1a5, 'h1a6:'h280, 'h1a7:'h1a8, 'h1a9:'h283, 'h1ac:'h1ad, 'h1ae:'h288,
			'h1af:'h1b0, 'h1b1:'h28a, 'h1b2:'h28b, 'h1b3:'h1b4, 'h1b5:'h1b6, 'h1b7:'h292,
			'h1b8:'h1b9, 'h1bc:'h1bd, 'h1c4:'h1c6, 'h1c5:'h1c6, 'h1c7:'h1c9, 'h1c8:'h1c9,
			'h1ca:'h1cc, 'h1f1:'h1f3, 'h1f2:'h1f3, 'h1f4:'h1f5, 'h1f6:'h195, 'h1f7:'h1bf,
			'h220:'h19e, 'h23a:'h2c65, 'h23b:'h23c, 'h23d:'h19a, 'h23e:'h2c66, 'h241:'h242,
			'h243:'h180, 'h244:'h289, 'h245:'h28c, 'h370:'h371, 'h372:'h373, 'h376:'h377,
			'h37f:'h3f3, 'h386:'h3ac, 'h388:'h3ad, 'h389:'h3ae, 'h38a:'h3af, 'h38c:'h3cc,
			'h38e:'h3cd, 'h38f:'h3ce, 'h3cf:'h3d7, 'h3f4:'h3b8, 'h3f7:'h3f8, 'h3f9:'h3f2,
			'h3fa:'h3fb, 'h3fd:'h37b, 'h3fe:'h37c, 'h3ff:'h37d, 'h4c0:'h4cf, 'h10c7:'h2d27,
			'h10cd:'h2d2d, 'h1cbd:'h10fd, 'h1cbe:'h10fe, 'h1cbf:'h10ff, 'h1e9e:'hdf,
			'h1fb8:'h1fb0, 'h1fb9:'h1fb1, 'h1fba:'h1f70, 'h1fbb:'h1f71, 'h1fbc:'h1fb3,
			'h1fcc:'h1fc3, 'h1fd8:'h1fd0, 'h1fd9:'h1fd1, 'h1fda:'h1f76, 'h1fdb:'h1f77,
			'h1fe8:'h1fe0, 'h1fe9:'h1fe1, 'h1fea:'h1f7a, 'h1feb:'h1f7b, 'h1fec:'h1fe5,
			'h1ff8:'h1f78, 'h1ff9:'h1f79, 'h1ffa:'h1f7c, 'h1ffb:'h1f7d, 'h1ffc:'h1ff3,
			'h2126:'h3c9, 'h212a:'h6b, 'h212b:'he5, 'h2132:'h214e, 'h2183:'h2184,
			'h2c60:'h2c61, 'h2c62:'h26b, 'h2c63:'h1d7d, 'h2c64:'h27d, 'h2c67:'h2c68,
			'h2c69:'h2c6a, 'h2c6b:'h2c6c, 'h2c6d:'h251, 'h2c6e:'h271, 'h2c6f:'h250,
			'h2c70:'h252, 'h2c72:'h2c73, 'h2c75:'h2c76, 'h2c7e:'h23f, 'h2c7f:'h240,
			'h2ceb:'h2cec, 'h2ced:'h2cee, 'h2cf2:'h2cf3, 'ha779:'ha77a, 'ha77b:'ha77c,
			'ha77d:'h1d79, 'ha78b:'ha78c, 'ha78d:'h265, 'ha790:'ha791, 'ha792:'ha793,
			'ha7aa:'h266, 'ha7ab:'h25c, 'ha7ac:'h261, 'ha7ad:'h26c, 'ha7ae:'h26a,
			'ha7b0:'h29e, 'ha7b1:'h287, 'ha7b2:'h29d, 'ha7b3:'hab53, 'ha7c2:'ha7c3,
			'ha7c4:'ha794, 'ha7c5:'h282, 'ha7c6:'h1d8e
		};
	end

	always @(posedge clk or negedge arst_n) begin
		folded_t want;
		if (!arst_n) begin
			errors <= 0;
			pending <= 0;
		end else begin
			if (in_valid && in_ready)
				folded_q.push_back(fold(code_point));
			if (out_valid && out_ready) begin
				if (folded_q.size() == 0) begin
					errors <= errors + 1;
					if (errors < 10)
						$display("unexpected result %h changed=%b", lower_point, changed);
				end else begin
					want = folded_q.pop_front();
					if (want.point !== lower_point || want.flag !== changed) begin
						errors <= errors + 1;
						if (errors < 10)
							$display("mismatch: expected %h/%b, got %h/%b",
								want.point, want.flag, lower_point, changed);
					end
				end
			end
			pending <= folded_q.size();
		end
	end

endmodule

// ===== verif/tb_unicode_to_lowercase.sv =====
`timescale 1ns / 1ps
module tb_unicode_to_lowercase;
	import ulc_pkg::*;

	logic           clk = 0;
	logic           arst_n = 0;
	logic           in_valid = 0;
	logic           in_ready;
	logic [CpW-1:0] code_point = '0;
	logic           out_valid;
	logic           out_ready = 0;
	logic [CpW-1:0] lower_point;
	logic           changed;
	int             errors;
	int             pending;
	int             send_idle = 0;
	int             recv_stall = 0;
	bit             hold_off = 0;
	int             cycles = 0;

	always #5 clk = ~clk;

	unicode_to_lowercase u_top (.*);

	ulc_checker u_chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 200000) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(negedge clk)
		out_ready <= !hold_off && ($urandom_range(99) >= recv_stall);

	function automatic logic [CpW-1:0] pick_point();
		int unsigned k;
		k = $urandom_range(9);
		case (k)
			0, 1: return CpW'($urandom_range(32'h7f));
			2, 3: return CpW'($urandom_range(32'h1ff, 32'h100));
			4: return CpW'($urandom_range(32'h52f, 32'h200));
			5: return CpW'($urandom_range(32'h1fff, 32'h1000));
			6: return CpW'($urandom_range(32'h2cff, 32'h2100));
			7: return CpW'($urandom_range(32'ha7ff, 32'ha600));
			8: return CpW'($urandom_range(32'hffff, 32'hff00));
			default: return CpW'($urandom());
		endcase
	endfunction

	task automatic send(logic [CpW-1:0] cp);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		code_point <= cp;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	logic [CpW-1:0] directed [$] = '{
		21'h0, 21'h41, 21'h5a, 21'h40, 21'h5b, 21'hd7, 21'hde, 21'h101, 21'h100,
		21'h13a, 21'h139, 21'h1f00, 21'h1f08, 21'h1f59, 21'h1f5a, 21'h1c90, 21'h13a0,
		21'h130, 21'h4c0, 21'h3a2, 21'hff3a, 21'h10000, 21'h10ffff, 21'h110000,
		21'h1fffff
	};

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		foreach (directed[i])
			send(directed[i]);
		for (int p = 0; p < 4; p++) begin
			send_idle = (p == 1 || p == 3) ? 70 : (p == 3 ? 19 : 0);
			recv_stall = (p == 2) ? 70 : (p == 3 ? 19 : 0);
			if (p == 3)
				send_idle = 19;
			if (p == 0)
				fork
					begin
						hold_off = 1;
						repeat (40) @(negedge clk);
						hold_off = 0;
					end
				join_none
			for (int n = 0; n < 100; n++)
				send(pick_point());
		end
		in_valid <= 0;
		while (pending != 0 && cycles < 200000)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== unicode_to_lowercase.f =====
src/ulc_pkg.sv
src/ulc_match.sv
src/unicode_to_lowercase.sv
verif/ulc_checker.sv
verif/tb_unicode_to_lowercase.sv
